FILE: hw/rtl/trf_pkg.sv
// Shared widths and constants for the triangle flattening pipeline.
package trf_pkg;
    localparam int VW = 32;
    localparam int EW = 33;
    localparam int MW = 32;
    localparam int PW = 64;
    localparam int SW = 66;
    localparam int RW = 33;
    localparam int QW = 35;
    localparam int XW = 2 * QW;
    localparam int CW = 24;
    localparam int OW = 31;
    localparam logic [CW-1:0] SCALE_RESET = 24'd65536;
endpackage

FILE: hw/rtl/trf_in_if.sv
// Triangle input channel carrying three vertices per transaction.
interface trf_in_if;
    import trf_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] vertex_a_x;
    logic signed [VW-1:0] vertex_a_y;
    logic signed [VW-1:0] vertex_a_z;
    logic signed [VW-1:0] vertex_b_x;
    logic signed [VW-1:0] vertex_b_y;
    logic signed [VW-1:0] vertex_b_z;
    logic signed [VW-1:0] vertex_c_x;
    logic signed [VW-1:0] vertex_c_y;
    logic signed [VW-1:0] vertex_c_z;
    modport source (output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
                    vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, input ready);
    modport sink (input valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
                  vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, output ready);
endinterface

FILE: hw/rtl/trf_out_if.sv
// Flattened triangle result channel.
interface trf_out_if;
    import trf_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [OW-1:0]        second_u;
    logic signed [VW-1:0] third_u;
    logic [OW-1:0]        third_v;
    logic                 degenerate;
    logic                 saturated;
    modport source (output valid, second_u, third_u, third_v, degenerate, saturated,
                    input ready);
    modport sink (input valid, second_u, third_u, third_v, degenerate, saturated,
                  output ready);
endinterface

FILE: hw/rtl/triangle_rest_flattening.sv
// Triangle flattening: lays one 3D triangle into a scaled 2D frame.
//
// One triangle enters on i_tri per transaction and one result leaves on o_uv.
// The result gives second_u = |B-A|, third_u as the projection of C-A onto
// B-A, and third_v as the height of C above edge AB, each scaled by the
// Q8.16 scale register and saturated, with degenerate and saturated flags.
// The scale register is written through i_scale_we and i_scale_wdata. The user must
// write it only while the pipeline is empty; the block itself does not enforce this.
// The pipeline has 110 register stages, and a new triangle is taken every
// cycle while o_uv is not stalled. The length is set by the two square root
// pipelines (34 stages each, 33 of them deciding one root bit) and the
// restoring divider (36 stages, 35 of them deciding one quotient bit), plus
// edge, product, sum, square, scale and output stages.
// When o_uv is stalled the whole pipeline holds and i_tri.ready drops, so no
// transaction is lost or repeated. A synchronous reset empties the pipeline
// and sets the scale to 1.0.
module triangle_rest_flattening
    import trf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_scale_we,
    input  logic [CW-1:0] i_scale_wdata,
    trf_in_if.sink        i_tri,
    trf_out_if.source     o_uv
);
    logic [CW-1:0] r_scale;
    logic          en;

    logic signed [EW-1:0] r1_e0 [3];
    logic signed [EW-1:0] r1_e1 [3];
    logic                 r1_vld;
    logic [PW-1:0] r2_p00 [3];
    logic [PW-1:0] r2_p11 [3];
    logic [PW-1:0] r2_p01 [3];
    logic          r2_sgn [3];
    logic          r2_vld;
    logic [SW-1:0] r3_l0, r3_l1, r3_dpos, r3_dneg;
    logic          r3_vld;

    logic [SW-1:0] r_a_n    [RW+1];
    logic [RW-1:0] r_a_root [RW+1];
    logic [SW-1:0] r_a_sq   [RW+1];
    logic [SW-1:0] r_a_l1   [RW+1];
    logic [SW-1:0] r_a_dmag [RW+1];
    logic          r_a_neg  [RW+1];
    logic          r_a_dg   [RW+1];
    logic          r_a_vld  [RW+1];
    logic [RW-1:0] n_a_root [RW];
    logic [SW-1:0] n_a_sq   [RW];
    logic [SW:0]   n_a_cand [RW];

    logic [RW-1:0] r_d_rem [QW+1];
    logic [QW-1:0] r_d_num [QW+1];
    logic [RW-1:0] r_d_div [QW+1];
    logic [QW-1:0] r_d_q   [QW+1];
    logic [SW-1:0] r_d_l1  [QW+1];
    logic          r_d_neg [QW+1];
    logic          r_d_dg  [QW+1];
    logic          r_d_vld [QW+1];
    logic [RW-1:0] n_d_rem [QW];
    logic [QW-1:0] n_d_q   [QW];
    logic [RW:0]   n_d_r2  [QW];

    logic [RW-1:0] r_m_u1;
    logic [QW-1:0] r_m_u2;
    logic [XW-1:0] r_m_u2sq;
    logic [SW-1:0] r_m_l1;
    logic          r_m_neg, r_m_dg, r_m_vld;
    logic [QW-1:0] n_m_u2;

    logic [SW-1:0] r_b_n    [RW+1];
    logic [RW-1:0] r_b_root [RW+1];
    logic [SW-1:0] r_b_sq   [RW+1];
    logic [RW-1:0] r_b_u1   [RW+1];
    logic [QW-1:0] r_b_u2   [RW+1];
    logic          r_b_neg  [RW+1];
    logic          r_b_dg   [RW+1];
    logic          r_b_vld  [RW+1];
    logic [RW-1:0] n_b_root [RW];
    logic [SW-1:0] n_b_sq   [RW];
    logic [SW:0]   n_b_cand [RW];

    logic [RW+CW-17:0] r_s_u1;
    logic [QW+CW-17:0] r_s_u2;
    logic [RW+CW-17:0] r_s_v2;
    logic              r_s_neg, r_s_dg, r_s_vld;
    logic [RW+CW-1:0]  n_s_p1, n_s_p3;
    logic [QW+CW-1:0]  n_s_p2;

    logic [OW-1:0]        r_o_second_u, r_o_third_v;
    logic signed [VW-1:0] r_o_third_u;
    logic                 r_o_degenerate, r_o_saturated, r_o_vld;
    logic [RW+CW-17:0]    n_o_u1, n_o_v2;
    logic [QW+CW-17:0]    n_o_u2, n_o_lim;
    logic                 n_o_s1, n_o_s2, n_o_s3;

    logic signed [EW-1:0] n1_e0 [3];
    logic signed [EW-1:0] n1_e1 [3];
    logic [MW-1:0]        n2_m0 [3];
    logic [MW-1:0]        n2_m1 [3];
    logic [XW:0]          n_rad;

    assign en          = !r_o_vld || o_uv.ready;
    assign i_tri.ready = en;

    always_comb begin
        n1_e0[0] = EW'(i_tri.vertex_b_x) - EW'(i_tri.vertex_a_x);
        n1_e0[1] = EW'(i_tri.vertex_b_y) - EW'(i_tri.vertex_a_y);
        n1_e0[2] = EW'(i_tri.vertex_b_z) - EW'(i_tri.vertex_a_z);
        n1_e1[0] = EW'(i_tri.vertex_c_x) - EW'(i_tri.vertex_a_x);
        n1_e1[1] = EW'(i_tri.vertex_c_y) - EW'(i_tri.vertex_a_y);
        n1_e1[2] = EW'(i_tri.vertex_c_z) - EW'(i_tri.vertex_a_z);
        for (int i = 0; i < 3; i++) begin
            n2_m0[i] = r1_e0[i][EW-1] ? MW'(-r1_e0[i]) : MW'(r1_e0[i]);
            n2_m1[i] = r1_e1[i][EW-1] ? MW'(-r1_e1[i]) : MW'(r1_e1[i]);
        end
    end

    always_comb begin
        for (int k = 0; k < RW; k++) begin
            n_a_cand[k] = {1'b0, r_a_sq[k]} + ((SW+1)'(r_a_root[k]) << (RW - k))
                          + ((SW+1)'(1) << (2 * (RW - 1 - k)));
            n_a_root[k] = r_a_root[k];
            n_a_sq[k]   = r_a_sq[k];
            if ({1'b0, r_a_n[k]} >= n_a_cand[k]) begin
                n_a_root[k] = r_a_root[k] | (RW'(1) << (RW - 1 - k));
                n_a_sq[k]   = n_a_cand[k][SW-1:0];
            end
            n_b_cand[k] = {1'b0, r_b_sq[k]} + ((SW+1)'(r_b_root[k]) << (RW - k))
                          + ((SW+1)'(1) << (2 * (RW - 1 - k)));
            n_b_root[k] = r_b_root[k];
            n_b_sq[k]   = r_b_sq[k];
            if ({1'b0, r_b_n[k]} >= n_b_cand[k]) begin
                n_b_root[k] = r_b_root[k] | (RW'(1) << (RW - 1 - k));
                n_b_sq[k]   = n_b_cand[k][SW-1:0];
            end
        end
        for (int k = 0; k < QW; k++) begin
            n_d_r2[k]  = {r_d_rem[k], r_d_num[k][QW-1-k]};
            n_d_q[k]   = r_d_q[k];
            n_d_rem[k] = n_d_r2[k][RW-1:0];
            if (n_d_r2[k] >= {1'b0, r_d_div[k]}) begin
                n_d_rem[k] = RW'(n_d_r2[k] - {1'b0, r_d_div[k]});
                n_d_q[k]   = r_d_q[k] | (QW'(1) << (QW - 1 - k));
            end
        end
    end

    assign n_m_u2 = r_d_dg[QW] ? '0 : r_d_q[QW];
    assign n_rad  = (XW+1)'(r_m_l1) - (XW+1)'(r_m_u2sq);
    assign n_s_p1 = (RW+CW)'(r_b_u1[RW]) * (RW+CW)'(r_scale);
    assign n_s_p2 = (QW+CW)'(r_b_u2[RW]) * (QW+CW)'(r_scale);
    assign n_s_p3 = (RW+CW)'(r_b_root[RW]) * (RW+CW)'(r_scale);

    always_comb begin
        n_o_lim = r_s_neg ? (QW+CW-16)'(33'h080000000) : (QW+CW-16)'(33'h07FFFFFFF);
        n_o_s1  = r_s_u1 > (RW+CW-16)'(33'h07FFFFFFF);
        n_o_s2  = r_s_u2 > n_o_lim;
        n_o_s3  = r_s_v2 > (RW+CW-16)'(33'h07FFFFFFF);
        n_o_u1  = n_o_s1 ? (RW+CW-16)'(33'h07FFFFFFF) : r_s_u1;
        n_o_u2  = n_o_s2 ? n_o_lim : r_s_u2;
        n_o_v2  = n_o_s3 ? (RW+CW-16)'(33'h07FFFFFFF) : r_s_v2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_scale_we) begin
            r_scale <= i_scale_wdata;
        end
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r_m_vld <= 1'b0;
            r_s_vld <= 1'b0;
            r_o_vld <= 1'b0;
            for (int k = 0; k <= RW; k++) begin
                r_a_vld[k] <= 1'b0;
                r_b_vld[k] <= 1'b0;
            end
            for (int k = 0; k <= QW; k++) begin
                r_d_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r1_vld     <= i_tri.valid;
            r2_vld     <= r1_vld;
            r3_vld     <= r2_vld;
            r_a_vld[0] <= r3_vld;
            for (int k = 0; k < RW; k++) begin
                r_a_vld[k+1] <= r_a_vld[k];
                r_b_vld[k+1] <= r_b_vld[k];
            end
            r_d_vld[0] <= r_a_vld[RW];
            for (int k = 0; k < QW; k++) begin
                r_d_vld[k+1] <= r_d_vld[k];
            end
            r_m_vld    <= r_d_vld[QW];
            r_b_vld[0] <= r_m_vld;
            r_s_vld    <= r_b_vld[RW];
            r_o_vld    <= r_s_vld;
        end
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_e0[i]  <= n1_e0[i];
                r1_e1[i]  <= n1_e1[i];
                r2_p00[i] <= PW'(n2_m0[i]) * PW'(n2_m0[i]);
                r2_p11[i] <= PW'(n2_m1[i]) * PW'(n2_m1[i]);
                r2_p01[i] <= PW'(n2_m0[i]) * PW'(n2_m1[i]);
                r2_sgn[i] <= r1_e0[i][EW-1] ^ r1_e1[i][EW-1];
            end
            r3_l0   <= SW'(r2_p00[0]) + SW'(r2_p00[1]) + SW'(r2_p00[2]);
            r3_l1   <= SW'(r2_p11[0]) + SW'(r2_p11[1]) + SW'(r2_p11[2]);
            r3_dpos <= (r2_sgn[0] ? '0 : SW'(r2_p01[0])) + (r2_sgn[1] ? '0 : SW'(r2_p01[1]))
                       + (r2_sgn[2] ? '0 : SW'(r2_p01[2]));
            r3_dneg <= (r2_sgn[0] ? SW'(r2_p01[0]) : '0) + (r2_sgn[1] ? SW'(r2_p01[1]) : '0)
                       + (r2_sgn[2] ? SW'(r2_p01[2]) : '0);

            r_a_n[0]    <= r3_l0;
            r_a_root[0] <= '0;
            r_a_sq[0]   <= '0;
            r_a_l1[0]   <= r3_l1;
            r_a_neg[0]  <= r3_dpos < r3_dneg;
            r_a_dmag[0] <= (r3_dpos < r3_dneg) ? r3_dneg - r3_dpos : r3_dpos - r3_dneg;
            r_a_dg[0]   <= r3_l0 == '0;
            for (int k = 0; k < RW; k++) begin
                r_a_n[k+1]    <= r_a_n[k];
                r_a_root[k+1] <= n_a_root[k];
                r_a_sq[k+1]   <= n_a_sq[k];
                r_a_l1[k+1]   <= r_a_l1[k];
                r_a_dmag[k+1] <= r_a_dmag[k];
                r_a_neg[k+1]  <= r_a_neg[k];
                r_a_dg[k+1]   <= r_a_dg[k];
            end

            r_d_rem[0] <= RW'(r_a_dmag[RW] >> QW);
            r_d_num[0] <= r_a_dmag[RW][QW-1:0];
            r_d_div[0] <= r_a_root[RW];
            r_d_q[0]   <= '0;
            r_d_l1[0]  <= r_a_l1[RW];
            r_d_neg[0] <= r_a_neg[RW];
            r_d_dg[0]  <= r_a_dg[RW];
            for (int k = 0; k < QW; k++) begin
                r_d_rem[k+1] <= n_d_rem[k];
                r_d_num[k+1] <= r_d_num[k];
                r_d_div[k+1] <= r_d_div[k];
                r_d_q[k+1]   <= n_d_q[k];
                r_d_l1[k+1]  <= r_d_l1[k];
                r_d_neg[k+1] <= r_d_neg[k];
                r_d_dg[k+1]  <= r_d_dg[k];
            end

            r_m_u1   <= r_d_div[QW];
            r_m_u2   <= n_m_u2;
            r_m_u2sq <= XW'(n_m_u2) * XW'(n_m_u2);
            r_m_l1   <= r_d_l1[QW];
            r_m_neg  <= r_d_neg[QW];
            r_m_dg   <= r_d_dg[QW];

            r_b_n[0]    <= n_rad[XW] ? '0 : SW'(n_rad);
            r_b_root[0] <= '0;
            r_b_sq[0]   <= '0;
            r_b_u1[0]   <= r_m_u1;
            r_b_u2[0]   <= r_m_u2;
            r_b_neg[0]  <= r_m_neg;
            r_b_dg[0]   <= r_m_dg;
            for (int k = 0; k < RW; k++) begin
                r_b_n[k+1]    <= r_b_n[k];
                r_b_root[k+1] <= n_b_root[k];
                r_b_sq[k+1]   <= n_b_sq[k];
                r_b_u1[k+1]   <= r_b_u1[k];
                r_b_u2[k+1]   <= r_b_u2[k];
                r_b_neg[k+1]  <= r_b_neg[k];
                r_b_dg[k+1]   <= r_b_dg[k];
            end

            r_s_u1  <= n_s_p1[RW+CW-1:16];
            r_s_u2  <= n_s_p2[QW+CW-1:16];
            r_s_v2  <= n_s_p3[RW+CW-1:16];
            r_s_neg <= r_b_neg[RW];
            r_s_dg  <= r_b_dg[RW];

            r_o_second_u   <= OW'(n_o_u1);
            r_o_third_u    <= r_s_neg ? -VW'(n_o_u2) : VW'(n_o_u2);
            r_o_third_v    <= OW'(n_o_v2);
            r_o_degenerate <= r_s_dg;
            r_o_saturated  <= n_o_s1 || n_o_s2 || n_o_s3;
        end
    end

    assign o_uv.valid      = r_o_vld;
    assign o_uv.second_u   = r_o_second_u;
    assign o_uv.third_u    = r_o_third_u;
    assign o_uv.third_v    = r_o_third_v;
    assign o_uv.degenerate = r_o_degenerate;
    assign o_uv.saturated  = r_o_saturated;

`ifndef SYNTHESIS
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_uv.valid && o_uv.degenerate |-> o_uv.second_u == '0 && o_uv.third_u == '0)
        else $error("degenerate result with nonzero u coordinates");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_uv.valid)
        else $error("result valid after reset");
    a_zero_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_uv.valid && r_scale == '0 |-> o_uv.third_v == '0 && !o_uv.saturated)
        else $error("nonzero result with zero scale");
    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && !o_uv.ready |-> !i_tri.ready)
        else $error("input taken while output stalled");
`endif
endmodule

FILE: tb/tb_triangle_rest_flattening.sv
// Self-checking testbench for the triangle flattening pipeline with scale register phases.
module tb_triangle_rest_flattening;
    import trf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 111;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF;
    localparam logic [63:0] NEG_MAX = 64'h8000_0000;

    typedef struct packed {
        logic signed [VW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    } triangle_t;

    typedef struct packed {
        logic [OW-1:0]        second_u;
        logic signed [VW-1:0] third_u;
        logic [OW-1:0]        third_v;
        logic                 degenerate;
        logic                 saturated;
    } flat_t;

    logic i_clk;
    logic i_rst_n;
    logic i_scale_we;
    logic [CW-1:0] i_scale_wdata;

    trf_in_if  tri_if ();
    trf_out_if uv_if ();

    triangle_rest_flattening u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_scale_we    (i_scale_we),
        .i_scale_wdata (i_scale_wdata),
        .i_tri         (tri_if.sink),
        .o_uv          (uv_if.source)
    );

    triangle_t   pending_tris[$];
    flat_t       expected_uvs[$];
    logic [CW-1:0] model_scale;
    logic        tri_taken;
    logic        no_idle;
    int          send_gap;
    int          recv_gap;
    int          hold_cycles;
    bit          hold_done;
    int          cycle_count;
    int          error_count;
    int          tri_count;
    int          uv_count;
    int          degen_count;
    int          sat_count;

    function automatic logic [127:0] floor_sqrt(logic [127:0] n);
        logic [127:0] r;
        logic [127:0] c;
        r = '0;
        for (int b = 40; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= n) begin
                r = c;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] apply_scale(logic [127:0] mag, logic [63:0] limit,
                                                logic [CW-1:0] sc, inout logic sat);
        logic [127:0] r;
        if (mag >= (128'd1 << 40)) begin
            r = (sc == 0) ? 128'd0 : {64'd0, limit} + 128'd1;
        end else begin
            r = (mag * sc) >> 16;
        end
        if (r > {64'd0, limit}) begin
            sat = 1'b1;
            r = {64'd0, limit};
        end
        return r[63:0];
    endfunction

    function automatic flat_t flatten(triangle_t t, logic [CW-1:0] sc);
        logic signed [127:0] e0[3];
        logic signed [127:0] e1[3];
        logic signed [127:0] dot;
        logic [127:0] len0, len1, u1, u2, v2, dmag;
        logic neg, sat;
        logic [63:0] s1, s2, s3;
        flat_t f;
        e0[0] = 128'(t.bx) - 128'(t.ax);
        e0[1] = 128'(t.by) - 128'(t.ay);
        e0[2] = 128'(t.bz) - 128'(t.az);
        e1[0] = 128'(t.cx) - 128'(t.ax);
        e1[1] = 128'(t.cy) - 128'(t.ay);
        e1[2] = 128'(t.cz) - 128'(t.az);
        len0 = 0;
        len1 = 0;
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            len0 = len0 + e0[i] * e0[i];
            len1 = len1 + e1[i] * e1[i];
            dot = dot + e0[i] * e1[i];
        end
        neg = 1'b0;
        sat = 1'b0;
        u1 = 0;
        u2 = 0;
        f.degenerate = (len0 == 0);
        if (f.degenerate) begin
            v2 = floor_sqrt(len1);
        end else begin
            u1 = floor_sqrt(len0);
            neg = dot < 0;
            dmag = neg ? -dot : dot;
            u2 = dmag / u1;
            if (u2 >= (128'd1 << 40)) begin
                v2 = 0;
            end else if (len1 < u2 * u2) begin
                v2 = 0;
            end else begin
                v2 = floor_sqrt(len1 - u2 * u2);
            end
        end
        s1 = apply_scale(u1, POS_MAX, sc, sat);
        s2 = apply_scale(u2, neg ? NEG_MAX : POS_MAX, sc, sat);
        s3 = apply_scale(v2, POS_MAX, sc, sat);
        f.second_u = s1[OW-1:0];
        f.third_u = neg ? -s2[31:0] : s2[31:0];
        f.third_v = s3[OW-1:0];
        f.saturated = sat;
        return f;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    function automatic logic signed [VW-1:0] near(logic signed [VW-1:0] base, int span);
        return base + $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic triangle_t random_triangle();
        triangle_t t;
        int mode;
        int span;
        mode = $urandom_range(0, 9);
        span = ($urandom_range(0, 3) == 0) ? 32'h7FFF_FFFF : (1 << $urandom_range(4, 24));
        t.ax = $urandom();
        t.ay = $urandom();
        t.az = $urandom();
        if (mode < 2) begin
            t = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom()};
        end else begin
            t.bx = near(t.ax, span);
            t.by = near(t.ay, span);
            t.bz = near(t.az, span);
            t.cx = near(t.ax, span);
            t.cy = near(t.ay, span);
            t.cz = near(t.az, span);
            if (mode == 2) begin
                {t.bx, t.by, t.bz} = {t.ax, t.ay, t.az};
            end else if (mode == 3) begin
                t.cx = t.ax + 2 * (t.bx - t.ax);
                t.cy = t.ay + 2 * (t.by - t.ay);
                t.cz = t.az + 2 * (t.bz - t.az);
            end
        end
        return t;
    endfunction

    task automatic add_tri(triangle_t t);
        pending_tris.insert(pending_tris.size(), t);
    endtask

    task automatic load_directed();
        logic signed [VW-1:0] mx;
        logic signed [VW-1:0] mn;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        add_tri('0);
        add_tri({mn, mn, mn, mx, mx, mx, mx, mn, mx});
        add_tri({mx, mx, mx, mn, mn, mn, mn, mx, mn});
        add_tri({mn, mn, mn, mx, mx, mx, mn, mn, mn});
        add_tri({mn, mn, mn, mn, mn, mn, mx, mx, mx});
        add_tri({mx, mn, mx, mx, mn, mx, mn, mx, mn});
        add_tri({32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0,
                 32'sd0, 32'sd65536, 32'sd0});
        add_tri({32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0,
                 -32'sd65536, 32'sd65536, 32'sd0});
        add_tri({32'sd0, 32'sd0, 32'sd0, 32'sd3, 32'sd0, 32'sd0,
                 32'sd2, 32'sd5, 32'sd0});
        add_tri({32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd1,
                 32'sd1, 32'sd1, 32'sd1});
        add_tri({32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0,
                 mx, mx, mx});
        add_tri({32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0,
                 mn, 32'sd0, 32'sd0});
        add_tri({32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd0,
                 32'sd1, 32'sd0, 32'sd0});
        add_tri({-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
                 32'sd0, 32'sd0, 32'sd0});
        add_tri({32'sh1234_5678, -32'sh0123_4567, 32'sh0FED_CBA9,
                 32'sh1234_5678, -32'sh0123_4567, 32'sh0FED_CBA9,
                 mx, mx, mn});
        add_tri({32'sd0, 32'sd0, 32'sd0, 32'sh0100_0000, 32'sd0, 32'sd0,
                 32'sh0080_0000, 32'sh0200_0000, 32'sd0});
        add_tri({32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                 32'sh5555_5555, 32'sh5555_5555, 32'shAAAA_AAAA});
    endtask

    task automatic wait_idle();
        while (pending_tris.size() != 0 || tri_if.valid || expected_uvs.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        tri_taken <= tri_if.valid && tri_if.ready;
        if (!i_rst_n) begin
            model_scale <= SCALE_RESET;
        end else begin
            if (i_scale_we) begin
                model_scale <= i_scale_wdata;
            end
            if (tri_if.valid && tri_if.ready) begin
                expected_uvs.insert(expected_uvs.size(), flatten({tri_if.vertex_a_x,
                    tri_if.vertex_a_y, tri_if.vertex_a_z, tri_if.vertex_b_x,
                    tri_if.vertex_b_y, tri_if.vertex_b_z, tri_if.vertex_c_x,
                    tri_if.vertex_c_y, tri_if.vertex_c_z}, model_scale));
                tri_count <= tri_count + 1;
            end
        end
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!tri_if.valid || tri_taken)) begin
            if (send_gap > 0 || pending_tris.size() == 0) begin
                tri_if.valid <= 1'b0;
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end
            end else begin
                {tri_if.vertex_a_x, tri_if.vertex_a_y, tri_if.vertex_a_z,
                 tri_if.vertex_b_x, tri_if.vertex_b_y, tri_if.vertex_b_z,
                 tri_if.vertex_c_x, tri_if.vertex_c_y, tri_if.vertex_c_z}
                    <= pending_tris.pop_front();
                tri_if.valid <= 1'b1;
                send_gap <= pick_gap();
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            uv_if.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (!hold_done && uv_count >= 20 && pending_tris.size() >= 20) begin
            uv_if.ready <= 1'b0;
            hold_cycles <= 400;
            hold_done <= 1'b1;
        end else if (recv_gap > 0) begin
            uv_if.ready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end else begin
            uv_if.ready <= 1'b1;
            recv_gap <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        flat_t exp_uv;
        if (i_rst_n && uv_if.valid && uv_if.ready) begin
            uv_count <= uv_count + 1;
            if (expected_uvs.size() == 0) begin
                $error("Unexpected transaction on the result channel");
                error_count <= error_count + 1;
            end else begin
                exp_uv = expected_uvs.pop_front();
                degen_count <= degen_count + exp_uv.degenerate;
                sat_count <= sat_count + exp_uv.saturated;
                if (uv_if.second_u !== exp_uv.second_u) begin
                    $error("second_u: expected %0d, got %0d", exp_uv.second_u, uv_if.second_u);
                    error_count <= error_count + 1;
                end
                if (uv_if.third_u !== exp_uv.third_u) begin
                    $error("third_u: expected %0d, got %0d", exp_uv.third_u, uv_if.third_u);
                    error_count <= error_count + 1;
                end
                if (uv_if.third_v !== exp_uv.third_v) begin
                    $error("third_v: expected %0d, got %0d", exp_uv.third_v, uv_if.third_v);
                    error_count <= error_count + 1;
                end
                if (uv_if.degenerate !== exp_uv.degenerate) begin
                    $error("degenerate: expected %0b, got %0b", exp_uv.degenerate,
                           uv_if.degenerate);
                    error_count <= error_count + 1;
                end
                if (uv_if.saturated !== exp_uv.saturated) begin
                    $error("saturated: expected %0b, got %0b", exp_uv.saturated,
                           uv_if.saturated);
                    error_count <= error_count + 1;
                end
            end
        end
    end

    initial begin
        logic [CW-1:0] scales[7];
        scales = '{24'd65536, 24'd0, 24'hFFFFFF, 24'd1, 24'd131072, 24'd0, 24'd65536};
        scales[5] = CW'($urandom_range(1, 24'hFFFFFF));
        i_rst_n = 1'b0;
        i_scale_we = 1'b0;
        i_scale_wdata = '0;
        tri_if.valid = 1'b0;
        {tri_if.vertex_a_x, tri_if.vertex_a_y, tri_if.vertex_a_z, tri_if.vertex_b_x,
         tri_if.vertex_b_y, tri_if.vertex_b_z, tri_if.vertex_c_x, tri_if.vertex_c_y,
         tri_if.vertex_c_z} = '0;
        uv_if.ready = 1'b0;
        no_idle = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        hold_cycles = 0;
        hold_done = 1'b0;
        cycle_count = 0;
        error_count = 0;
        tri_count = 0;
        uv_count = 0;
        degen_count = 0;
        sat_count = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int p = 0; p < 7; p++) begin
            if (p > 0) begin
                i_scale_we <= 1'b1;
                i_scale_wdata <= scales[p];
                @(negedge i_clk);
                i_scale_we <= 1'b0;
            end
            no_idle = (p == 3);
            if (p == 0 || p == 2) begin
                load_directed();
            end
            for (int n = 0; n < 145; n++) begin
                add_tri(random_triangle());
            end
            wait_idle();
        end
        $display("Sent %0d triangles over 7 scale settings, checked %0d results",
                 tri_count, uv_count);
        $display("Degenerate results: %0d, saturated results: %0d", degen_count, sat_count);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
